// ===== rtl/core/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and helper functions for the XTEA cipher core.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned CYCLES      = 32;
  localparam int unsigned HALF_ROUNDS = 2 * CYCLES;
  // input register plus one register per half-round cell
  localparam int unsigned LATENCY     = HALF_ROUNDS + 1;
  localparam int unsigned NUM_KEYS    = 4;
  localparam int unsigned ADDR_W      = 4;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  typedef logic [NUM_KEYS-1:0][31:0] key_t;

  typedef struct packed {
    logic        valid;
    logic        decrypt;
    logic [31:0] v0;
    logic [31:0] v1;
  } stage_t;

  function automatic logic [31:0] mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // delta times n, wrapped to 32 bits
  function automatic logic [31:0] delta_mul(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(n);
    return prod[31:0];
  endfunction

  // sum seen by half-round j when encrypting
  function automatic logic [31:0] enc_sum(input int unsigned j);
    return delta_mul((j + 1) / 2);
  endfunction

  // sum seen by half-round j when decrypting
  function automatic logic [31:0] dec_sum(input int unsigned j);
    return delta_mul(CYCLES - (j + 1) / 2);
  endfunction

endpackage

// ===== rtl/core/xtea_cell.sv =====
// ----------------------------------------------------------------------------
// xtea_cell
// One XTEA half-round: updates one half of the block and registers the
// result for the next cell. Keeps its own registered round-key terms.
// ----------------------------------------------------------------------------
module xtea_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  upd_second,
  input  logic [31:0]           sum_enc,
  input  logic [31:0]           sum_dec,
  input  xtea_pkg::key_t        key,
  input  xtea_pkg::stage_t      stage_in,
  output xtea_pkg::stage_t      stage_out
);

  logic [31:0] term_enc;
  logic [31:0] term_dec;
  logic [1:0]  idx_enc;
  logic [1:0]  idx_dec;
  logic        tgt_second;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [31:0] f;
  logic [31:0] tgt_next;

  // updates of v1 take the key by sum[12:11], updates of v0 by sum[1:0];
  // decryption swaps which half this position updates
  assign idx_enc = upd_second ? sum_enc[12:11] : sum_enc[1:0];
  assign idx_dec = upd_second ? sum_dec[1:0]   : sum_dec[12:11];

  always_ff @(posedge clk) begin
    term_enc <= sum_enc + key[idx_enc];
    term_dec <= sum_dec + key[idx_dec];
  end

  assign tgt_second = upd_second ^ stage_in.decrypt;
  assign src        = tgt_second ? stage_in.v0 : stage_in.v1;
  assign tgt        = tgt_second ? stage_in.v1 : stage_in.v0;
  assign f          = xtea_pkg::mix(src) ^ (stage_in.decrypt ? term_dec : term_enc);
  assign tgt_next   = stage_in.decrypt ? (tgt - f) : (tgt + f);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.decrypt <= stage_in.decrypt;
    stage_out.v0      <= tgt_second ? stage_in.v0 : tgt_next;
    stage_out.v1      <= tgt_second ? tgt_next : stage_in.v1;
  end

endmodule

// ===== rtl/core/xtea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// xtea_block_cipher
// XTEA encrypt/decrypt core, 64-bit block, 128-bit key, built as a chain
// of 64 half-round cells, two per XTEA cycle.
// ----------------------------------------------------------------------------
// Channel  | Handshake                         | Payload
// ---------+-----------------------------------+-----------------------------
// input    | start && !busy                    | block_first, block_second,
//          |                                   | decrypt
// result   | done (one-cycle strobe)           | out_first, out_second
// config   | psel && penable && pwrite&&pready | paddr[3:2] = key word, pwdata
//
// A new block is taken every cycle; busy is always low.
// Each result passes through one input register and one register per
// half-round cell (64 cells) before it appears on done.
// Results leave in start order; the receiver cannot stall the chain.
// Synchronous reset clears the key words and all in-flight transactions.
// Round-key terms are re-registered every cycle, so a key write takes
// effect for the next transaction started after the write.
// ----------------------------------------------------------------------------
module xtea_block_cipher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   block_first,
  input  logic [31:0]                   block_second,
  input  logic                          decrypt,
  output logic                          done,
  output logic [31:0]                   out_first,
  output logic [31:0]                   out_second,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xtea_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  xtea_pkg::key_t   key;
  xtea_pkg::stage_t in_stage;
  xtea_pkg::stage_t chain [0:xtea_pkg::HALF_ROUNDS];
  logic             cfg_wr;
  logic [1:0]       key_sel;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign key_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = key[key_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wr) begin
      key[key_sel] <= pwdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage.valid <= 1'b0;
    end else begin
      in_stage.valid <= start && !busy;
    end
    in_stage.decrypt <= decrypt;
    in_stage.v0      <= block_first;
    in_stage.v1      <= block_second;
  end

  assign chain[0] = in_stage;

  for (genvar j = 0; j < xtea_pkg::HALF_ROUNDS; j++) begin : g_cell
    xtea_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .upd_second (1'((j % 2))),
      .sum_enc    (xtea_pkg::enc_sum(j)),
      .sum_dec    (xtea_pkg::dec_sum(j)),
      .key        (key),
      .stage_in   (chain[j]),
      .stage_out  (chain[j+1])
    );
  end

  assign done       = chain[xtea_pkg::HALF_ROUNDS].valid;
  assign out_first  = chain[xtea_pkg::HALF_ROUNDS].v0;
  assign out_second = chain[xtea_pkg::HALF_ROUNDS].v1;

  // every accepted transaction yields its result on done
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(xtea_pkg::LATENCY) done)
    else $error("result missing after accepted transaction");

  // no result without a matching start
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, xtea_pkg::LATENCY))
    else $error("result without an accepted transaction");

  // key write lands in the addressed word
  a_key_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (key[$past(key_sel)] == $past(pwdata)))
    else $error("key word not updated by write");

endmodule
